FILE: sv/npcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_pkg
// Types, constants and helpers shared by the nearest palette colour search.
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned RGB_W    = 3 * CHAN_W;
  localparam int unsigned C15_W    = 15;
  localparam int unsigned PACKED_W = 32;
  localparam int unsigned IDX_OUT_W = 8;
  localparam int unsigned DIST_W   = 18;

  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 64;

  localparam logic [CHAN_W-1:0] ALPHA_BYTE = 8'hFF;
  localparam logic [DIST_W-1:0] DIST_MAX   = 18'd195075;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // 5-bit channel to 8 bits: v*8+4
  function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] v);
    return {v, 3'b100};
  endfunction

  function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d * d;
  endfunction

endpackage

`default_nettype wire

FILE: sv/nearest_palette_color_search_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_search_core
// Palette store with a nearest-colour search over all entries.
// ----------------------------------------------------------------------------
// A load request (tuser = 0) writes one palette entry; its result (alpha 0xFF,
// blue, green, red) is ready the cycle after acceptance.
// A lookup request (tuser = 1) walks entries 0 .. PALETTE_ENTRIES-1 through
// the palette memory, one read per cycle. Its result passes through the reads,
// then the distance and compare stages and the output register. One request
// is in work at a time; the next is taken at the earliest at the edge where
// the previous result leaves the output register. Entries must be loaded
// before a lookup scans them.
module nearest_palette_color_search_core #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // entry_index[7:0], red[15:8], green[23:16], blue[31:24], color15[46:32]
  input  wire logic [npcs_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // opcode[0]
  input  wire logic                               s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // packed_color[31:0], nearest_index[39:32], nearest_distance[57:40]
  output logic [npcs_pkg::M_TDATA_W-1:0]          m_axis_tdata_o
);

  localparam int unsigned IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  localparam int unsigned CW = npcs_pkg::CHAN_W;
  localparam int unsigned DW = npcs_pkg::DIST_W;

  // request fields
  logic [7:0]                 in_idx;
  logic [CW-1:0]              in_red, in_green, in_blue;
  logic [npcs_pkg::C15_W-1:0] in_c15;
  logic                       in_acc, in_load, in_lookup;

  assign in_idx   = s_axis_tdata_i[7:0];
  assign in_red   = s_axis_tdata_i[15:8];
  assign in_green = s_axis_tdata_i[23:16];
  assign in_blue  = s_axis_tdata_i[31:24];
  assign in_c15   = s_axis_tdata_i[46:32];

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_load   = in_acc && (npcs_pkg::opcode_e'(s_axis_tuser_i) == npcs_pkg::OP_LOAD);
  assign in_lookup = in_acc && (npcs_pkg::opcode_e'(s_axis_tuser_i) == npcs_pkg::OP_LOOKUP);

  npcs_pkg::state_e state_q, state_d;
  logic             out_free, done_load;

  // palette memory, blue/green/red from the top
  logic [npcs_pkg::RGB_W-1:0] palette_mem [PALETTE_ENTRIES];

  // lookup target
  logic [CW-1:0] tgt_r_q, tgt_g_q, tgt_b_q;

  // read issue
  logic             issue_on_q;
  logic [IDX_W-1:0] issue_idx_q;

  // read data stage
  logic                       rd_vld_q, rd_last_q;
  logic [IDX_W-1:0]           rd_idx_q;
  logic [npcs_pkg::RGB_W-1:0] rd_data_q;

  // distance stage
  logic             dist_vld_q, dist_last_q;
  logic [IDX_W-1:0] dist_idx_q;
  logic [DW-1:0]    dist_q, dist_d;

  // running best
  logic [IDX_W-1:0] best_idx_q;
  logic [DW-1:0]    best_d_q;
  logic             better;

  // output register
  logic                            out_valid_q, out_valid_d;
  logic [npcs_pkg::M_TDATA_W-1:0]  out_data_q;

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    done_load       = 1'b0;
    case (state_q)
      npcs_pkg::ST_IDLE: begin
        s_axis_tready_o = out_free;
        if (in_lookup) begin
          state_d = npcs_pkg::ST_SCAN;
        end
      end
      npcs_pkg::ST_SCAN: begin
        if (dist_vld_q && dist_last_q) begin
          state_d = npcs_pkg::ST_DONE;
        end
      end
      npcs_pkg::ST_DONE: begin
        if (out_free) begin
          done_load = 1'b1;
          state_d   = npcs_pkg::ST_IDLE;
        end
      end
      default: state_d = npcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= npcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // no writes during a scan, so reads never race a write
  always_ff @(posedge clk_i) begin
    if (in_load && ({1'b0, in_idx} < 9'(PALETTE_ENTRIES))) begin
      palette_mem[in_idx[IDX_W-1:0]] <= {in_blue, in_green, in_red};
    end
    if (issue_on_q) begin
      rd_data_q <= palette_mem[issue_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_on_q  <= 1'b0;
      issue_idx_q <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      dist_vld_q  <= 1'b0;
      dist_last_q <= 1'b0;
    end else begin
      if (in_lookup) begin
        issue_on_q  <= 1'b1;
        issue_idx_q <= '0;
      end else if (issue_on_q) begin
        if (issue_idx_q == LAST_IDX) begin
          issue_on_q <= 1'b0;
        end else begin
          issue_idx_q <= issue_idx_q + 1'b1;
        end
      end
      rd_vld_q    <= issue_on_q;
      rd_last_q   <= issue_on_q && (issue_idx_q == LAST_IDX);
      dist_vld_q  <= rd_vld_q;
      dist_last_q <= rd_vld_q && rd_last_q;
    end
  end

  always_comb begin
    dist_d = DW'(npcs_pkg::sq_diff(tgt_r_q, rd_data_q[CW-1:0]))
           + DW'(npcs_pkg::sq_diff(tgt_g_q, rd_data_q[2*CW-1:CW]))
           + DW'(npcs_pkg::sq_diff(tgt_b_q, rd_data_q[3*CW-1:2*CW]));
  end

  assign better = (dist_idx_q == '0) || (dist_q < best_d_q);

  always_ff @(posedge clk_i) begin
    if (in_lookup) begin
      tgt_r_q <= npcs_pkg::expand5(in_c15[4:0]);
      tgt_g_q <= npcs_pkg::expand5(in_c15[9:5]);
      tgt_b_q <= npcs_pkg::expand5(in_c15[14:10]);
    end
    if (issue_on_q) begin
      rd_idx_q <= issue_idx_q;
    end
    if (rd_vld_q) begin
      dist_q     <= dist_d;
      dist_idx_q <= rd_idx_q;
    end
    if (dist_vld_q && better) begin
      best_idx_q <= dist_idx_q;
      best_d_q   <= dist_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (in_load || done_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      out_data_q <= {6'd0, {DW{1'b0}}, {npcs_pkg::IDX_OUT_W{1'b0}},
                     npcs_pkg::ALPHA_BYTE, in_blue, in_green, in_red};
    end else if (done_load) begin
      out_data_q <= {6'd0, best_d_q, npcs_pkg::IDX_OUT_W'(best_idx_q),
                     {npcs_pkg::PACKED_W{1'b0}}};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_issue_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_on_q |-> (state_q == npcs_pkg::ST_SCAN))
    else $error("palette read issued outside a scan");

  a_lookup_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_lookup |=> (issue_on_q && (issue_idx_q == '0)))
    else $error("lookup did not start the scan at entry zero");

  a_last_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_vld_q && dist_last_q) |=> (state_q == npcs_pkg::ST_DONE))
    else $error("scan end did not reach result state");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[57:40] <= npcs_pkg::DIST_MAX))
    else $error("result distance out of range");

endmodule

`default_nettype wire
